// ----- design/tmst_pkg.sv -----
// tmst_pkg: shared widths, request codes, fade constants and sequencer states
// for the timed message slot table
// no dependencies

package tmst_pkg;

    // default slot count handed to the top level
    localparam int SLOTS_DEF = 4;

    // field widths of one request
    localparam int REQ_W    = 3;
    localparam int NOW_W    = 48;
    localparam int ID_W     = 3;
    localparam int TEXT_W   = 16;
    localparam int COLOUR_W = 24;
    localparam int DUR_W    = 32;
    localparam int MAXE_W   = 3;

    // field widths of one result
    localparam int ALPHA_W = 8;
    localparam int TALLY_W = 3;
    localparam int SLOT_W  = 3;

    // request tdata: now, id, text, empty, colour, duration, max entries
    localparam int IN_BITS   = NOW_W + ID_W + TEXT_W + 1 + COLOUR_W + DUR_W + MAXE_W;
    localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;

    // result tdata: ok, slot, evicted, text, colour, alpha, tally
    localparam int OUT_BITS   = 1 + SLOT_W + 1 + TEXT_W + COLOUR_W + ALPHA_W + TALLY_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // fade ramps, both below 2^FADE_W
    localparam int FADE_W  = 13;
    localparam int MUL_W   = FADE_W + ALPHA_W;
    localparam int QBIT_W  = $clog2(ALPHA_W);
    localparam logic [FADE_W-1:0]  FADE_IN_MS  = FADE_W'(150);
    localparam logic [FADE_W-1:0]  FADE_OUT_MS = FADE_W'(400);
    localparam logic [ALPHA_W-1:0] ALPHA_MAX   = ALPHA_W'(255);

    // request codes
    localparam logic [REQ_W-1:0] REQ_PUT   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_SET   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_HIDE  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 3'd3;
    localparam logic [REQ_W-1:0] REQ_SNAP  = 3'd4;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_EVICT,
        ST_WRITE,
        ST_SN_CHECK,
        ST_SN_AGE,
        ST_SN_LEFT,
        ST_SN_MUL,
        ST_SN_DIV,
        ST_SN_EMIT,
        ST_SN_NEXT,
        ST_RESULT,
        ST_WAIT
    } state_t;

endpackage

// ----- design/timed_message_slot_table_top.sv -----
// timed_message_slot_table_top: slot table of timed messages with a small sequencer
// around one shared 48-bit add/subtract unit
// depends on tmst_pkg

// Usage
//   Requests enter on the s_ stream (s_tuser = request kind) and are taken one at a
//   time: s_tready is high only while the block is idle. Each request answers with
//   one or more results on the m_ stream; m_tlast marks the last one, m_tuser flags
//   a snapshot entry. Put, set, hide, clear and unknown requests give one result.
//   A snapshot gives one entry per visible message (up to max entries) and a count.
// Sequencing
//   Set, hide and clear go from dispatch to the result state, a good set by way
//   of the write state; the block is idle again once the last result is taken.
//   Put goes through the write state too, after a search of every slot for the
//   oldest when every slot is busy. Snapshot visits each slot in turn; a slot
//   inside a fade ramp runs the multiply step and the 8-step restoring divider per ramp, all on the shared unit.
// Reset and stall
//   aresetn (synchronous, active low) frees every slot and drops m_tvalid.
//   A held result waits in the output register and the sequencer holds until
//   m_tready takes it; nothing is lost or repeated.

module timed_message_slot_table_top #(
    parameter int SLOTS = tmst_pkg::SLOTS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // now_ms, toast_id, text_ref, text_empty, colour, duration_ms, max_entries, pad
    input  logic [tmst_pkg::IN_DATA_W-1:0]   s_tdata,
    // req_type
    input  logic [tmst_pkg::REQ_W-1:0]       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // ok, slot_number, evicted, entry_text, entry_colour, alpha, tally
    output logic [tmst_pkg::OUT_DATA_W-1:0]  m_tdata,
    // is_entry
    output logic                             m_tuser,
    // last
    output logic                             m_tlast
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int XW    = (IDX_W > 3) ? IDX_W : 3;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int CW    = (CNT_W > 3) ? CNT_W : 3;
    localparam int NW    = tmst_pkg::NOW_W;
    localparam int FW    = tmst_pkg::FADE_W;
    localparam int MW    = tmst_pkg::MUL_W;
    localparam int AW    = tmst_pkg::ALPHA_W;
    localparam int QW    = tmst_pkg::QBIT_W;

    // slot index to 1-based slot number, three bits
    function automatic logic [2:0] slot_code(input logic [IDX_W-1:0] idx);
        logic [XW:0] w;
        w = (XW + 1)'(idx) + (XW + 1)'(1);
        return w[2:0];
    endfunction

    // sequencer and control registers
    tmst_pkg::state_t state_reg, state_next;
    logic [SLOTS-1:0] busy_reg, busy_next;
    logic [IDX_W-1:0] scan_reg, scan_next;
    logic [IDX_W-1:0] target_reg, target_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [QW-1:0]    bit_reg, bit_next;
    logic             fout_reg, fout_next;
    logic             evict_reg, evict_next;
    logic             res_ok_reg, res_ok_next;
    logic [2:0]       res_slot_reg, res_slot_next;
    logic             out_valid_reg, out_valid_next;

    // arithmetic registers
    logic [NW-1:0]    best_born_reg, best_born_next;
    logic [MW-1:0]    rem_reg, rem_next;
    logic [FW-1:0]    den_reg, den_next;
    logic [AW-1:0]    quo_reg, quo_next;
    logic [AW-1:0]    alpha_reg, alpha_next;

    // output register
    logic [tmst_pkg::OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic                            out_user_reg, out_user_next;
    logic                            out_last_reg, out_last_next;
    logic                            out_load;
    logic                            slot_wr;

    // captured request
    logic [tmst_pkg::REQ_W-1:0]    req_reg;
    logic [NW-1:0]                 now_reg;
    logic [tmst_pkg::ID_W-1:0]     id_reg;
    logic [tmst_pkg::TEXT_W-1:0]   text_reg;
    logic                          empty_reg;
    logic [tmst_pkg::COLOUR_W-1:0] colour_reg;
    logic [tmst_pkg::DUR_W-1:0]    dur_reg;
    logic [tmst_pkg::MAXE_W-1:0]   maxe_reg;

    // slot storage
    logic [NW-1:0]                 slot_born_reg   [SLOTS];
    logic [NW-1:0]                 slot_exp_reg    [SLOTS];
    logic [tmst_pkg::COLOUR_W-1:0] slot_colour_reg [SLOTS];
    logic [tmst_pkg::TEXT_W-1:0]   slot_text_reg   [SLOTS];
    logic                          slot_empty_reg  [SLOTS];

    // shared unit
    logic [NW-1:0] unit_a, unit_b;
    logic          unit_sub;
    logic [NW:0]   unit_sum;
    logic [NW-1:0] unit_res;
    logic          unit_carry;

    // misc decode
    logic [NW-1:0]    born_rd, exp_rd;
    logic             busy_rd, exp_set, expired, fade_hit, scan_last, any_free, id_ok;
    logic [IDX_W-1:0] free_idx, id_index;
    logic [XW-1:0]    id_m1;
    logic [FW-1:0]    fade_lim;
    logic [AW-1:0]    quo_new;
    logic             accept;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == tmst_pkg::ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

    // slot reads at the scan index
    assign born_rd   = slot_born_reg[scan_reg];
    assign exp_rd    = slot_exp_reg[scan_reg];
    assign busy_rd   = busy_reg[scan_reg];
    assign exp_set   = (exp_rd != '0);
    assign scan_last = (scan_reg == IDX_W'(SLOTS - 1));

    // id check for set and hide
    assign id_m1    = XW'(id_reg) - XW'(1);
    assign id_index = id_m1[IDX_W-1:0];
    assign id_ok    = (id_reg != '0) && (32'(id_reg) <= 32'(SLOTS)) && busy_reg[id_index];

    // lowest free slot
    assign any_free = ~&busy_reg;
    always_comb begin
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!busy_reg[i]) free_idx = IDX_W'(i);
        end
    end

    // shared unit operand select
    always_comb begin
        unit_a   = '0;
        unit_b   = '0;
        unit_sub = 1'b1;
        case (state_reg)
            tmst_pkg::ST_EVICT: begin
                unit_a = born_rd;
                unit_b = best_born_reg;
            end
            tmst_pkg::ST_WRITE: begin
                unit_a   = now_reg;
                unit_b   = NW'(dur_reg);
                unit_sub = 1'b0;
            end
            tmst_pkg::ST_SN_CHECK: begin
                unit_a = now_reg;
                unit_b = exp_rd;
            end
            tmst_pkg::ST_SN_AGE: begin
                unit_a = now_reg;
                unit_b = born_rd;
            end
            tmst_pkg::ST_SN_LEFT: begin
                unit_a = exp_rd;
                unit_b = now_reg;
            end
            tmst_pkg::ST_SN_MUL: begin
                unit_a = NW'({rem_reg, 8'h00});
                unit_b = NW'(rem_reg);
            end
            tmst_pkg::ST_SN_DIV: begin
                unit_a = NW'(rem_reg);
                unit_b = NW'(den_reg) << bit_reg;
            end
            default: ;
        endcase
    end

    // add or subtract, carry out means no borrow
    assign unit_sum   = {1'b0, unit_a} + {1'b0, (unit_sub ? ~unit_b : unit_b)} + (NW + 1)'(unit_sub);
    assign unit_res   = unit_sum[NW-1:0];
    assign unit_carry = unit_sum[NW];
    assign expired    = !unit_res[NW-1];

    // ramp window test on the difference
    assign fade_lim = (state_reg == tmst_pkg::ST_SN_AGE) ? tmst_pkg::FADE_IN_MS
                                                         : tmst_pkg::FADE_OUT_MS;
    assign fade_hit = (unit_res[NW-1:FW] == '0) && (unit_res[FW-1:0] < fade_lim);

    // quotient with this step's bit
    always_comb begin
        quo_new = quo_reg;
        if (unit_carry) quo_new[bit_reg] = 1'b1;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tmst_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = tmst_pkg::ST_DISPATCH;
            end
            tmst_pkg::ST_DISPATCH: begin
                case (req_reg)
                    tmst_pkg::REQ_PUT:
                        state_next = any_free ? tmst_pkg::ST_WRITE : tmst_pkg::ST_EVICT;
                    tmst_pkg::REQ_SET:
                        state_next = id_ok ? tmst_pkg::ST_WRITE : tmst_pkg::ST_RESULT;
                    tmst_pkg::REQ_SNAP:
                        state_next = tmst_pkg::ST_SN_CHECK;
                    default:
                        state_next = tmst_pkg::ST_RESULT;
                endcase
            end
            tmst_pkg::ST_EVICT: begin
                if (scan_last) state_next = tmst_pkg::ST_WRITE;
            end
            tmst_pkg::ST_WRITE:
                state_next = tmst_pkg::ST_RESULT;
            tmst_pkg::ST_SN_CHECK: begin
                if (!busy_rd || slot_empty_reg[scan_reg] || (exp_set && expired))
                    state_next = tmst_pkg::ST_SN_NEXT;
                else
                    state_next = tmst_pkg::ST_SN_AGE;
            end
            tmst_pkg::ST_SN_AGE: begin
                if (fade_hit)
                    state_next = tmst_pkg::ST_SN_MUL;
                else if (exp_set)
                    state_next = tmst_pkg::ST_SN_LEFT;
                else
                    state_next = tmst_pkg::ST_SN_EMIT;
            end
            tmst_pkg::ST_SN_LEFT:
                state_next = fade_hit ? tmst_pkg::ST_SN_MUL : tmst_pkg::ST_SN_EMIT;
            tmst_pkg::ST_SN_MUL:
                state_next = tmst_pkg::ST_SN_DIV;
            tmst_pkg::ST_SN_DIV: begin
                if (bit_reg == '0) begin
                    if (!fout_reg && exp_set)
                        state_next = tmst_pkg::ST_SN_LEFT;
                    else
                        state_next = tmst_pkg::ST_SN_EMIT;
                end
            end
            tmst_pkg::ST_SN_EMIT: begin
                if (alpha_reg != '0 && count_reg < CW'(maxe_reg))
                    state_next = tmst_pkg::ST_WAIT;
                else
                    state_next = tmst_pkg::ST_SN_NEXT;
            end
            tmst_pkg::ST_SN_NEXT:
                state_next = scan_last ? tmst_pkg::ST_RESULT : tmst_pkg::ST_SN_CHECK;
            tmst_pkg::ST_RESULT:
                state_next = tmst_pkg::ST_WAIT;
            tmst_pkg::ST_WAIT: begin
                if (m_tready)
                    state_next = out_last_reg ? tmst_pkg::ST_IDLE : tmst_pkg::ST_SN_NEXT;
            end
            default:
                state_next = tmst_pkg::ST_IDLE;
        endcase
    end

    // datapath and output control
    always_comb begin
        busy_next      = busy_reg;
        scan_next      = scan_reg;
        target_next    = target_reg;
        count_next     = count_reg;
        bit_next       = bit_reg;
        fout_next      = fout_reg;
        evict_next     = evict_reg;
        res_ok_next    = res_ok_reg;
        res_slot_next  = res_slot_reg;
        out_valid_next = out_valid_reg;
        best_born_next = best_born_reg;
        rem_next       = rem_reg;
        den_next       = den_reg;
        quo_next       = quo_reg;
        alpha_next     = alpha_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        out_last_next  = out_last_reg;
        out_load       = 1'b0;
        slot_wr        = 1'b0;
        case (state_reg)
            tmst_pkg::ST_DISPATCH: begin
                res_ok_next   = 1'b1;
                res_slot_next = '0;
                evict_next    = 1'b0;
                count_next    = '0;
                scan_next     = '0;
                case (req_reg)
                    tmst_pkg::REQ_PUT: begin
                        if (any_free) target_next = free_idx;
                        else evict_next = 1'b1;
                    end
                    tmst_pkg::REQ_SET: begin
                        if (id_ok) target_next = id_index;
                        else res_ok_next = 1'b0;
                    end
                    tmst_pkg::REQ_HIDE: begin
                        if (id_ok) begin
                            busy_next[id_index] = 1'b0;
                            res_slot_next       = id_reg;
                        end else begin
                            res_ok_next = 1'b0;
                        end
                    end
                    tmst_pkg::REQ_CLEAR: begin
                        count_next = CW'($countones(busy_reg));
                        busy_next  = '0;
                    end
                    tmst_pkg::REQ_SNAP: ;
                    default:
                        res_ok_next = 1'b0;
                endcase
            end
            // oldest birth search, ties keep the lower slot
            tmst_pkg::ST_EVICT: begin
                if (scan_reg == '0 || !unit_carry) begin
                    best_born_next = born_rd;
                    target_next    = scan_reg;
                end
                if (!scan_last) scan_next = scan_reg + IDX_W'(1);
            end
            tmst_pkg::ST_WRITE: begin
                slot_wr               = 1'b1;
                busy_next[target_reg] = 1'b1;
                res_slot_next         = slot_code(target_reg);
            end
            // expiry check frees an expired slot
            tmst_pkg::ST_SN_CHECK: begin
                alpha_next = tmst_pkg::ALPHA_MAX;
                if (busy_rd && !slot_empty_reg[scan_reg] && exp_set && expired)
                    busy_next[scan_reg] = 1'b0;
            end
            tmst_pkg::ST_SN_AGE: begin
                rem_next  = MW'(unit_res[FW-1:0]);
                den_next  = tmst_pkg::FADE_IN_MS;
                fout_next = 1'b0;
            end
            tmst_pkg::ST_SN_LEFT: begin
                rem_next  = MW'(unit_res[FW-1:0]);
                den_next  = tmst_pkg::FADE_OUT_MS;
                fout_next = 1'b1;
            end
            // times 255 as a shift and subtract
            tmst_pkg::ST_SN_MUL: begin
                rem_next = unit_res[MW-1:0];
                bit_next = QW'(AW - 1);
                quo_next = '0;
            end
            // restoring divide, one quotient bit per cycle
            tmst_pkg::ST_SN_DIV: begin
                if (unit_carry) rem_next = unit_res[MW-1:0];
                quo_next = quo_new;
                bit_next = bit_reg - QW'(1);
                if (bit_reg == '0) begin
                    if (!fout_reg || quo_new < alpha_reg) alpha_next = quo_new;
                end
            end
            tmst_pkg::ST_SN_EMIT: begin
                if (alpha_reg != '0) begin
                    count_next = count_reg + CW'(1);
                    if (count_reg < CW'(maxe_reg)) begin
                        out_load      = 1'b1;
                        out_data_next = {3'b000, alpha_reg, slot_colour_reg[scan_reg],
                                         slot_text_reg[scan_reg], 1'b0,
                                         slot_code(scan_reg), 1'b1};
                        out_user_next = 1'b1;
                        out_last_next = 1'b0;
                    end
                end
            end
            tmst_pkg::ST_SN_NEXT: begin
                if (!scan_last) scan_next = scan_reg + IDX_W'(1);
            end
            tmst_pkg::ST_RESULT: begin
                out_load      = 1'b1;
                out_data_next = {count_reg[2:0], {AW{1'b0}}, {tmst_pkg::COLOUR_W{1'b0}},
                                 {tmst_pkg::TEXT_W{1'b0}}, evict_reg, res_slot_reg,
                                 res_ok_reg};
                out_user_next = 1'b0;
                out_last_next = 1'b1;
            end
            tmst_pkg::ST_WAIT: begin
                if (m_tready) out_valid_next = 1'b0;
            end
            default: ;
        endcase
        if (out_load) out_valid_next = 1'b1;
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= tmst_pkg::ST_IDLE;
            busy_reg      <= '0;
            out_valid_reg <= 1'b0;
            scan_reg      <= '0;
            bit_reg       <= '0;
            count_reg     <= '0;
            fout_reg      <= 1'b0;
            evict_reg     <= 1'b0;
            res_ok_reg    <= 1'b0;
        end else begin
            state_reg     <= state_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            scan_reg      <= scan_next;
            bit_reg       <= bit_next;
            count_reg     <= count_next;
            fout_reg      <= fout_next;
            evict_reg     <= evict_next;
            res_ok_reg    <= res_ok_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        target_reg    <= target_next;
        res_slot_reg  <= res_slot_next;
        best_born_reg <= best_born_next;
        rem_reg       <= rem_next;
        den_reg       <= den_next;
        quo_reg       <= quo_next;
        alpha_reg     <= alpha_next;
        out_data_reg  <= out_data_next;
        out_user_reg  <= out_user_next;
        out_last_reg  <= out_last_next;
        if (accept) begin
            req_reg    <= s_tuser;
            now_reg    <= s_tdata[47:0];
            id_reg     <= s_tdata[50:48];
            text_reg   <= s_tdata[66:51];
            empty_reg  <= s_tdata[67];
            colour_reg <= s_tdata[91:68];
            dur_reg    <= s_tdata[123:92];
            maxe_reg   <= s_tdata[126:124];
        end
    end

    // slot write for put and set, zero duration stays
    always_ff @(posedge aclk) begin
        if (slot_wr) begin
            slot_born_reg[target_reg]   <= now_reg;
            slot_exp_reg[target_reg]    <= (dur_reg != '0) ? unit_res : '0;
            slot_colour_reg[target_reg] <= colour_reg;
            slot_text_reg[target_reg]   <= text_reg;
            slot_empty_reg[target_reg]  <= empty_reg;
        end
    end

    // a result is only held while the sequencer waits on it
    a_valid_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> state_reg == tmst_pkg::ST_WAIT)
        else $error("result valid outside wait state");

    // slots do not change while idle with no request
    a_idle_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tmst_pkg::ST_IDLE && !accept) |=> $stable(busy_reg))
        else $error("slot busy bits changed while idle");

    // entries never carry a zero alpha
    a_entry_alpha: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_user_reg) |-> out_data_reg[52:45] != '0)
        else $error("snapshot entry with zero alpha");

    // the last result of a request returns the block to idle
    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && m_tready && out_last_reg) |=> state_reg == tmst_pkg::ST_IDLE)
        else $error("no return to idle after last result");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// testbench: directed and random stream traffic for the timed message slot table,
// with an in-bench predictor of the slot table and an in-order result checker
// depends on tmst_pkg and timed_message_slot_table_top

module testbench;
    import tmst_pkg::*;

    localparam int SLOTS        = SLOTS_DEF;
    localparam int RANDOM_ITEMS = 200;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 40;
    localparam int LIMIT        = 400000;
    localparam int MAX_REPORTS  = 40;

    // request kinds the block does not know
    localparam logic [REQ_W-1:0] REQ_SPARE_A = 3'd5;
    localparam logic [REQ_W-1:0] REQ_SPARE_B = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE_C = 3'd7;

    // bit offsets of the result fields in m_tdata
    localparam int O_OK    = 0;
    localparam int O_SLOT  = O_OK + 1;
    localparam int O_EV    = O_SLOT + SLOT_W;
    localparam int O_TEXT  = O_EV + 1;
    localparam int O_COL   = O_TEXT + TEXT_W;
    localparam int O_ALPHA = O_COL + COLOUR_W;
    localparam int O_TALLY = O_ALPHA + ALPHA_W;

    typedef struct packed {
        logic [REQ_W-1:0]    kind;
        logic [NOW_W-1:0]    now;
        logic [ID_W-1:0]     id;
        logic [TEXT_W-1:0]   text;
        logic                empty;
        logic [COLOUR_W-1:0] colour;
        logic [DUR_W-1:0]    dur;
        logic [MAXE_W-1:0]   max_entries;
    } msg_req_t;

    typedef struct packed {
        logic                ok;
        logic [SLOT_W-1:0]   slot;
        logic                evicted;
        logic                is_entry;
        logic [TEXT_W-1:0]   text;
        logic [COLOUR_W-1:0] colour;
        logic [ALPHA_W-1:0]  alpha;
        logic [TALLY_W-1:0]  tally;
        logic                last;
    } msg_result_t;

    logic                  aclk;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic [REQ_W-1:0]      s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;

    // predicted slot table
    logic                slot_busy   [SLOTS] = '{default: 1'b0};
    logic [NOW_W-1:0]    slot_born   [SLOTS];
    logic [NOW_W-1:0]    slot_expiry [SLOTS];
    logic [COLOUR_W-1:0] slot_colour [SLOTS];
    logic [TEXT_W-1:0]   slot_text   [SLOTS];
    logic                slot_empty  [SLOTS];

    msg_result_t pending_results[$];

    int  errors        = 0;
    int  requests_sent = 0;
    int  results_seen  = 0;
    int  entries_seen  = 0;
    int  evictions     = 0;
    int  cycle_count   = 0;
    int  hold_ask      = 0;
    int  hold_seen     = 0;
    int  rx_wait       = 0;
    bit  tx_idle_on    = 1'b1;
    bit  rx_stall_on   = 1'b1;

    timed_message_slot_table_top #(.SLOTS(SLOTS)) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT) begin
            $display("%0t: run limit of %0d cycles reached", $time, LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    // write one slot the way put and set do
    function automatic void store_slot(input int s, input msg_req_t r);
        slot_busy[s]   = 1'b1;
        slot_born[s]   = r.now;
        slot_expiry[s] = (r.dur == 0) ? '0 : r.now + NOW_W'(r.dur);
        slot_colour[s] = r.colour;
        slot_text[s]   = r.text;
        slot_empty[s]  = r.empty;
    endfunction

    // update the predicted table and queue the results one request causes
    function automatic void apply_request(input msg_req_t r);
        msg_result_t      res;
        int               slot;
        int               shown;
        int               fade;
        int               ramp;
        logic [NOW_W-1:0] age;
        logic [NOW_W-1:0] ttl;
        logic [NOW_W-1:0] since;
        res      = '0;
        res.last = 1'b1;
        case (r.kind)
            REQ_PUT: begin
                slot = -1;
                for (int i = 0; i < SLOTS; i++)
                    if (!slot_busy[i] && slot < 0) slot = i;
                // full table: oldest birth goes, lowest slot on a tie
                if (slot < 0) begin
                    slot = 0;
                    res.evicted = 1'b1;
                    evictions++;
                    for (int i = 1; i < SLOTS; i++)
                        if (slot_born[i] < slot_born[slot]) slot = i;
                end
                store_slot(slot, r);
                res.ok   = 1'b1;
                res.slot = SLOT_W'(slot + 1);
                pending_results.push_back(res);
            end
            REQ_SET, REQ_HIDE: begin
                if (r.id != 0 && r.id <= SLOTS && slot_busy[r.id - 1]) begin
                    if (r.kind == REQ_SET) store_slot(r.id - 1, r);
                    else slot_busy[r.id - 1] = 1'b0;
                    res.ok   = 1'b1;
                    res.slot = r.id;
                end
                pending_results.push_back(res);
            end
            REQ_CLEAR: begin
                shown = 0;
                for (int i = 0; i < SLOTS; i++) begin
                    if (slot_busy[i]) shown++;
                    slot_busy[i] = 1'b0;
                end
                res.ok    = 1'b1;
                res.tally = TALLY_W'(shown);
                pending_results.push_back(res);
            end
            REQ_SNAP: begin
                shown = 0;
                for (int i = 0; i < SLOTS; i++) begin
                    if (slot_busy[i] && !slot_empty[i]) begin
                        since = r.now - slot_expiry[i];
                        // expired when now is at or past expiry in wrapped time
                        if (slot_expiry[i] != 0 && !since[NOW_W-1]) begin
                            slot_busy[i] = 1'b0;
                        end else begin
                            age  = r.now - slot_born[i];
                            fade = 255;
                            if (age < 150) fade = int'(age) * 255 / 150;
                            ttl = slot_expiry[i] - r.now;
                            if (slot_expiry[i] != 0 && ttl < 400) begin
                                ramp = int'(ttl) * 255 / 400;
                                if (ramp < fade) fade = ramp;
                            end
                            if (fade != 0) begin
                                if (shown < r.max_entries) begin
                                    res          = '0;
                                    res.ok       = 1'b1;
                                    res.is_entry = 1'b1;
                                    res.slot     = SLOT_W'(i + 1);
                                    res.text     = slot_text[i];
                                    res.colour   = slot_colour[i];
                                    res.alpha    = ALPHA_W'(fade);
                                    pending_results.push_back(res);
                                end
                                shown++;
                            end
                        end
                    end
                end
                res       = '0;
                res.ok    = 1'b1;
                res.last  = 1'b1;
                res.tally = TALLY_W'(shown);
                pending_results.push_back(res);
            end
            default: begin
                pending_results.push_back(res);
            end
        endcase
    endfunction

    function automatic msg_req_t make_req(input logic [REQ_W-1:0] kind,
                                          input logic [NOW_W-1:0] now,
                                          input logic [ID_W-1:0] id,
                                          input logic [TEXT_W-1:0] text,
                                          input logic empty,
                                          input logic [COLOUR_W-1:0] colour,
                                          input logic [DUR_W-1:0] dur,
                                          input logic [MAXE_W-1:0] max_entries);
        msg_req_t r;
        r.kind        = kind;
        r.now         = now;
        r.id          = id;
        r.text        = text;
        r.empty       = empty;
        r.colour      = colour;
        r.dur         = dur;
        r.max_entries = max_entries;
        return r;
    endfunction

    // offer one request and predict its results once it is taken
    task automatic send_request(input msg_req_t r);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 12) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.kind;
        s_tdata  <= IN_DATA_W'({r.max_entries, r.dur, r.colour, r.empty,
                                r.text, r.id, r.now});
        do @(posedge aclk); while (!s_tready);
        requests_sent++;
        apply_request(r);
    endtask

    // stop offering and wait for every expected result
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        @(posedge aclk);
    endtask

    // receiver: random stall after each result while enabled, long hold on request
    always @(posedge aclk) begin
        int gap;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_seen != hold_ask) begin
            hold_seen <= hold_ask;
            rx_wait   <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (rx_wait > 0) begin
            rx_wait  <= rx_wait - 1;
            m_tready <= (rx_wait == 1);
        end else if (m_tvalid && m_tready && rx_stall_on) begin
            gap = $urandom_range(0, 12);
            rx_wait  <= gap;
            m_tready <= (gap == 0);
        end else begin
            m_tready <= 1'b1;
        end
    end

    function automatic void check_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
        if (want != got) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: mismatch in %s: expected %0h, actual %0h",
                         $time, name, want, got);
        end
    endfunction

    // result checker, in order against the oldest expectation
    always @(posedge aclk) begin
        msg_result_t got;
        msg_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.ok       = m_tdata[O_OK];
            got.slot     = m_tdata[O_SLOT +: SLOT_W];
            got.evicted  = m_tdata[O_EV];
            got.is_entry = m_tuser;
            got.text     = m_tdata[O_TEXT +: TEXT_W];
            got.colour   = m_tdata[O_COL +: COLOUR_W];
            got.alpha    = m_tdata[O_ALPHA +: ALPHA_W];
            got.tally    = m_tdata[O_TALLY +: TALLY_W];
            got.last     = m_tlast;
            results_seen++;
            if (got.is_entry) entries_seen++;
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: result with nothing expected: tdata %h tuser %b tlast %b",
                             $time, m_tdata, m_tuser, m_tlast);
            end else begin
                want = pending_results.pop_front();
                check_field("ok", want.ok, got.ok);
                check_field("slot_number", want.slot, got.slot);
                check_field("evicted", want.evicted, got.evicted);
                check_field("is_entry", want.is_entry, got.is_entry);
                check_field("entry_text", want.text, got.text);
                check_field("entry_colour", want.colour, got.colour);
                check_field("alpha", want.alpha, got.alpha);
                check_field("tally", want.tally, got.tally);
                check_field("last", want.last, got.last);
            end
        end
    end

    // fill the table, then a put on a full table with tied birth times
    task automatic test_fill_and_evict();
        send_request(make_req(REQ_CLEAR, 48'd0, 3'd0, 16'h0, 1'b0, 24'h0, 32'd0, 3'd0));
        send_request(make_req(REQ_PUT, 48'd1000, 3'd0, 16'hFFFF, 1'b0, 24'hFFFFFF,
                              32'd500, 3'd0));
        send_request(make_req(REQ_PUT, 48'd1000, 3'd0, 16'h1234, 1'b1, 24'h00FF00,
                              32'd0, 3'd0));
        // expiry wraps to zero, so this one stays
        send_request(make_req(REQ_PUT, 48'hFFFF_FFFF_FF9C, 3'd0, 16'h0F0F, 1'b0,
                              24'h123456, 32'd100, 3'd0));
        send_request(make_req(REQ_PUT, 48'd1000, 3'd0, 16'h0000, 1'b0, 24'h000000,
                              32'hFFFF_FFFF, 3'd0));
        send_request(make_req(REQ_PUT, 48'd1200, 3'd0, 16'hA5A5, 1'b0, 24'h5A5A5A,
                              32'd300, 3'd0));
    endtask

    // fade-in and fade-out overlap, then a count-only snapshot
    task automatic test_snapshot_fades();
        send_request(make_req(REQ_SNAP, 48'd1275, 3'd0, 16'h0, 1'b0, 24'h0, 32'd0, 3'd4));
        send_request(make_req(REQ_SNAP, 48'd1275, 3'd0, 16'h0, 1'b0, 24'h0, 32'd0, 3'd0));
    endtask

    // good and bad ids for set and hide
    task automatic test_set_and_hide();
        send_request(make_req(REQ_SET, 48'd1300, 3'd2, 16'hBEEF, 1'b0, 24'hABCDEF,
                              32'd0, 3'd0));
        send_request(make_req(REQ_SET, 48'd1300, 3'd0, 16'h1111, 1'b0, 24'h111111,
                              32'd10, 3'd0));
        send_request(make_req(REQ_SET, 48'd1300, 3'd7, 16'h2222, 1'b0, 24'h222222,
                              32'd10, 3'd0));
        send_request(make_req(REQ_HIDE, 48'd1300, 3'd5, 16'h0, 1'b0, 24'h0, 32'd0, 3'd0));
        send_request(make_req(REQ_HIDE, 48'd1300, 3'd3, 16'h0, 1'b0, 24'h0, 32'd0, 3'd0));
        send_request(make_req(REQ_HIDE, 48'd1300, 3'd3, 16'h0, 1'b0, 24'h0, 32'd0, 3'd0));
        send_request(make_req(REQ_SET, 48'd1300, 3'd3, 16'h3333, 1'b0, 24'h333333,
                              32'd10, 3'd0));
    endtask

    // zero alpha at birth, expiry exactly reached, more visible than max
    task automatic test_expiry();
        send_request(make_req(REQ_SNAP, 48'd1300, 3'd0, 16'h0, 1'b0, 24'h0, 32'd0, 3'd4));
        send_request(make_req(REQ_SNAP, 48'd1500, 3'd0, 16'h0, 1'b0, 24'h0, 32'd0, 3'd4));
        send_request(make_req(REQ_SNAP, 48'd1501, 3'd0, 16'h0, 1'b0, 24'h0, 32'd0, 3'd1));
    endtask

    task automatic test_unknown_and_clear();
        send_request(make_req(REQ_SPARE_A, 48'd1600, 3'd1, 16'h0, 1'b0, 24'h0, 32'd0, 3'd4));
        send_request(make_req(REQ_SPARE_B, 48'd1600, 3'd1, 16'h0, 1'b0, 24'h0, 32'd0, 3'd4));
        send_request(make_req(REQ_SPARE_C, 48'd1600, 3'd1, 16'h0, 1'b0, 24'h0, 32'd0, 3'd4));
        send_request(make_req(REQ_CLEAR, 48'd1600, 3'd0, 16'h0, 1'b0, 24'h0, 32'd0, 3'd0));
    endtask

    // mostly a running clock so fades and expiries are hit, some random noise
    task automatic test_random_traffic();
        msg_req_t         r;
        logic [NOW_W-1:0] wall_ms;
        int               pick;
        wall_ms = 48'hFFFF_FFFF_FFFF - 48'd15000;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0) begin
                tx_idle_on  = ($urandom_range(0, 3) != 0);
                rx_stall_on = ($urandom_range(0, 3) != 0);
            end
            wall_ms = wall_ms + NOW_W'($urandom_range(0, 250));
            pick = $urandom_range(0, 99);
            if (pick < 30)      r.kind = REQ_PUT;
            else if (pick < 45) r.kind = REQ_SET;
            else if (pick < 55) r.kind = REQ_HIDE;
            else if (pick < 59) r.kind = REQ_CLEAR;
            else if (pick < 94) r.kind = REQ_SNAP;
            else                r.kind = REQ_W'($urandom_range(REQ_SPARE_A, REQ_SPARE_C));
            r.now = wall_ms;
            if ($urandom_range(0, 19) == 0) r.now = {16'($urandom), $urandom};
            r.id = ($urandom_range(0, 9) == 0) ? ID_W'($urandom_range(0, 7))
                                               : ID_W'($urandom_range(1, SLOTS));
            r.text   = 16'($urandom);
            r.empty  = ($urandom_range(0, 7) == 0);
            r.colour = 24'($urandom);
            case ($urandom_range(0, 3))
                0:       r.dur = '0;
                1:       r.dur = $urandom_range(50, 1500);
                2:       r.dur = $urandom_range(100, 600);
                default: r.dur = $urandom;
            endcase
            r.max_entries = MAXE_W'($urandom_range(0, 7));
            send_request(r);
        end
        tx_idle_on  = 1'b1;
        rx_stall_on = 1'b1;
    endtask

    // receiver holds off while the sender keeps offering, then the sender pauses
    task automatic test_backpressure();
        logic [NOW_W-1:0] wall_ms;
        wall_ms = 48'd5000;
        hold_ask   <= hold_ask + 1;
        tx_idle_on  = 1'b0;
        for (int n = 0; n < 12; n++) begin
            wall_ms = wall_ms + 48'd60;
            if (n % 3 == 2)
                send_request(make_req(REQ_SNAP, wall_ms, 3'd0, 16'h0, 1'b0, 24'h0,
                                      32'd0, 3'd4));
            else
                send_request(make_req(REQ_PUT, wall_ms, 3'd0, 16'($urandom), 1'b0,
                                      24'($urandom), 32'd700, 3'd0));
        end
        tx_idle_on = 1'b1;
        wait_drained();
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_fill_and_evict();
        test_snapshot_fades();
        test_set_and_hide();
        test_expiry();
        test_unknown_and_clear();
        wait_drained();
        test_backpressure();
        test_random_traffic();
        wait_drained();
        repeat (SETTLE) @(posedge aclk);
        if (pending_results.size() != 0) errors++;
        $display("%0d requests sent, %0d results checked, %0d snapshot entries, %0d evictions",
                 requests_sent, results_seen, entries_seen, evictions);
        $display("%0d mismatches after %0d cycles", errors, cycle_count);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
